/* rtl/core/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// ssd_pkg
// shared constants for the surface scatter direction block
// ----------------------------------------------------------------------------
package ssd_pkg;

  // fraction bits of the quarter-wave cosine datapath
  localparam int TRIG_BITS = 30;

  // even polynomial coefficients of the quarter-wave cosine, Q2.30
  localparam logic signed [32:0] COS_COEF [8] = '{
    33'sd1073741824, 33'sd1324675879, 33'sd272375560, 33'sd22401992,
    33'sd987048,     33'sd27060,      33'sd506,       33'sd7
  };

  // configuration register indexes
  localparam logic [1:0] REG_NORMAL_X    = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y    = 2'd1;
  localparam logic [1:0] REG_SPECULARITY = 2'd2;

endpackage

/* rtl/core/ssd_sqrt.sv */
// ----------------------------------------------------------------------------
// ssd_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module ssd_sqrt #(
  parameter int RW = 15
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] v_i,
  output logic [RW-1:0]   root_o
);

  logic [RW:0]     rem_q  [0:RW-1];
  logic [RW-1:0]   root_q [0:RW-1];
  logic [2*RW-1:0] v_q    [0:RW-2];

  for (genvar j = 0; j < RW; j++) begin : g_step
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] v_in;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = v_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign v_in    = v_q[j-1];
    end

    always_comb begin
      rem_sh = {rem_in, v_in[2*RW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      diff   = rem_sh - trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= diff[RW:0];
          root_q[j] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh[RW:0];
          root_q[j] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end

    if (j < RW - 1) begin : g_vshift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[j] <= {v_in[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

/* rtl/core/surface_scatter_direction.sv */
// ----------------------------------------------------------------------------
// surface_scatter_direction
// outgoing particle direction after a wall hit, specular or diffuse
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one item: the incoming
//   direction and three uniform random fractions from an outside source
//   output channel (out_valid_o / out_stall_i) carries the new direction and
//   a flag that tells whether diffuse scatter was chosen
//   configuration port: wall normal x/y and specularity, to be written by the
//   user only while the block holds no item; the block itself does not enforce
//   this; writes to an unused index are dropped
//   pipeline depth is set mainly by the square root, one root bit per stage
//   throughput is one item per cycle while no held result is stalled; every
//   stage is a register so a new item enters while earlier ones are in flight
//   when the receiver stalls a held result, the whole pipeline freezes and
//   in_stall_o goes high; nothing is lost or repeated
//   reset clears all valid bits and loads normal (1,0) and specularity one
// ----------------------------------------------------------------------------
module surface_scatter_direction
  import ssd_pkg::*;
#(
  parameter int DIR_FRAC_BITS = 14,
  parameter int RAND_BITS     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_addr_i,
  input  logic [((DIR_FRAC_BITS+2) > (RAND_BITS+1) ?
                 (DIR_FRAC_BITS+2) : (RAND_BITS+1))-1:0] cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DIR_FRAC_BITS+1:0] dir_x_i,
  input  logic signed [DIR_FRAC_BITS+1:0] dir_y_i,
  input  logic [RAND_BITS-1:0]         rand_choice_i,
  input  logic [RAND_BITS-1:0]         rand_radius_i,
  input  logic [RAND_BITS-1:0]         rand_angle_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DIR_FRAC_BITS+1:0] new_dir_x_o,
  output logic signed [DIR_FRAC_BITS+1:0] new_dir_y_o,
  output logic                         was_diffuse_o
);

  localparam int F   = DIR_FRAC_BITS;
  localparam int DW  = F + 2;
  localparam int SW  = RAND_BITS + 1;
  localparam int RW  = F + 1;         // square root width
  localparam int VW  = 2 * RW;        // square root radicand width
  localparam int SQ  = F + 2;         // stage where the roots are ready
  localparam int NS  = F + 5;         // last stage, drives the outputs
  localparam int HC  = 10;            // stage where the cosine is ready

  localparam logic signed [2*DW-1:0] HALF_F    = (2*DW)'(1) << (F - 1);
  localparam logic signed [64:0]     HALF_T    = 65'sd1 <<< (TRIG_BITS - 1);
  localparam logic signed [RW+33:0]  HALF_TX   = (RW+34)'(1) << (TRIG_BITS - 1);
  localparam logic [61:0]            HALF_U    = 62'd1 << (TRIG_BITS - 1);
  localparam logic signed [DW+2:0]   WLO       = -((DW+3)'(1) <<< (DW - 1));
  localparam logic signed [DW+2:0]   WHI       = ((DW+3)'(1) <<< (DW - 1)) - 1;
  localparam logic signed [DW+2:0]   ONE       = (DW+3)'(1) <<< F;
  localparam logic signed [DW+2:0]   MONE      = -((DW+3)'(1) <<< F);
  localparam logic [SW-1:0]          QONE      = SW'(1) << RAND_BITS;
  localparam logic [30:0]            FULL_TURN = 31'd1 << TRIG_BITS;

  // ---------------- configuration registers ----------------
  logic signed [DW-1:0] normal_x_q, normal_y_q;
  logic [SW-1:0]        spec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_x_q <= DW'(1) << F;
      normal_y_q <= '0;
      spec_q     <= QONE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NORMAL_X:    normal_x_q <= cfg_wdata_i[DW-1:0];
        REG_NORMAL_Y:    normal_y_q <= cfg_wdata_i[DW-1:0];
        REG_SPECULARITY: spec_q     <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // the pipeline moves as a whole unless a held result is stalled
  logic          adv;
  logic [1:NS]   valid_q;

  assign adv        = !(valid_q[NS] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {in_valid_i, valid_q[1:NS-1]};
    end
  end

  // ---------------- stage 1: capture, scatter choice, radicands ----------------
  logic [SW-1:0]         qa, qb;
  logic [VW-1:0]         va, vb;
  logic                  spec_now;
  logic [1:NS]           spec_q_pipe;
  logic signed [DW-1:0]  dx1_q, dy1_q;
  logic [RAND_BITS-1:0]  ra1_q;
  logic [VW-1:0]         va1_q, vb1_q;

  always_comb begin
    qa       = {1'b0, rand_radius_i};
    qb       = QONE - qa;
    // any specularity at or above one means always specular
    spec_now = spec_q[RAND_BITS] || ({1'b0, rand_choice_i} < spec_q);
  end

  // scale r so that the integer root lands on F fraction bits
  if (2 * F >= RAND_BITS) begin : g_scale_up
    assign va = VW'(qa) << (2 * F - RAND_BITS);
    assign vb = VW'(qb) << (2 * F - RAND_BITS);
  end else begin : g_scale_dn
    assign va = VW'(qa >> (RAND_BITS - 2 * F));
    assign vb = VW'(qb >> (RAND_BITS - 2 * F));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= dir_x_i;
      dy1_q <= dir_y_i;
      ra1_q <= rand_angle_i;
      va1_q <= va;
      vb1_q <= vb;
      spec_q_pipe <= {spec_now, spec_q_pipe[1:NS-1]};
    end
  end

  // ---------------- square roots: stages 2 .. F+2 ----------------
  logic [RW-1:0] root_a, root_b;

  ssd_sqrt #(.RW(RW)) u_sqrt_along (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    (va1_q),
    .root_o (root_a)
  );

  ssd_sqrt #(.RW(RW)) u_sqrt_across (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    (vb1_q),
    .root_o (root_b)
  );

  // ---------------- cosine: stages 2 .. 10 ----------------
  logic [31:0]              phase2;
  logic [30:0]              x2_d;
  logic [30:0]              x2_q;
  logic [2:9]               neg_q;
  logic [61:0]              sq3, sq3r;
  logic signed [31:0]       hu_q   [3:9];
  logic signed [32:0]       hacc_q [3:9];
  logic signed [32:0]       cos_d;
  logic signed [32:0]       cd_q   [HC:SQ];

  always_comb begin
    phase2 = 32'(ra1_q) << (32 - RAND_BITS);
    // odd quadrants mirror the argument about a quarter turn
    x2_d   = phase2[30] ? (FULL_TURN - {1'b0, phase2[29:0]}) : {1'b0, phase2[29:0]};
    sq3    = {31'd0, x2_q} * {31'd0, x2_q};
    sq3r   = sq3 + HALF_U;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x2_q      <= x2_d;
      neg_q[2]  <= phase2[31] ^ phase2[30];
      hu_q[3]   <= signed'(sq3r[61:30]);
      hacc_q[3] <= COS_COEF[7];
      cd_q[HC]  <= cos_d;
      for (int k = 3; k <= 9; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      for (int k = 4; k <= 9; k++) begin
        hu_q[k] <= hu_q[k-1];
      end
      for (int k = HC + 1; k <= SQ; k++) begin
        cd_q[k] <= cd_q[k-1];
      end
    end
  end

  // horner steps, one multiply per stage
  for (genvar k = 4; k <= HC; k++) begin : g_horner
    logic signed [64:0] prod;
    logic signed [64:0] prod_r;
    logic signed [32:0] m;

    always_comb begin
      prod   = hacc_q[k-1] * hu_q[k-1];
      prod_r = prod + HALF_T;
      m      = prod_r[62:30];
    end

    if (k < HC) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (adv) begin
          hacc_q[k] <= COS_COEF[HC-k] - m;
        end
      end
    end else begin : g_last
      // quadrant sign folds into the last subtraction
      assign cos_d = neg_q[9] ? (m - COS_COEF[0]) : (COS_COEF[0] - m);
    end
  end

  // ---------------- specular frame: stages 2 .. 3 ----------------
  logic signed [2*DW-1:0] pxn, pyn, pyx, pxy;
  logic signed [DW+1:0]   pxn_q, pyn_q, pyx_q, pxy_q;
  logic signed [DW+2:0]   s_al, s_ac;
  logic signed [DW-1:0]   sa_q [3:SQ];
  logic signed [DW-1:0]   sx_q [3:SQ];

  always_comb begin
    pxn  = dx1_q * normal_x_q + HALF_F;
    pyn  = dy1_q * normal_y_q + HALF_F;
    pyx  = dy1_q * normal_x_q + HALF_F;
    pxy  = dx1_q * normal_y_q + HALF_F;
    s_al = -(pxn_q + pyn_q);
    s_ac = pyx_q - pxy_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxn_q <= pxn[2*DW-1:F];
      pyn_q <= pyn[2*DW-1:F];
      pyx_q <= pyx[2*DW-1:F];
      pxy_q <= pxy[2*DW-1:F];
      // out-of-range parts clamp to the word range before rotation
      sa_q[3] <= (s_al < WLO) ? WLO[DW-1:0] : (s_al > WHI) ? WHI[DW-1:0] : s_al[DW-1:0];
      sx_q[3] <= (s_ac < WLO) ? WLO[DW-1:0] : (s_ac > WHI) ? WHI[DW-1:0] : s_ac[DW-1:0];
      for (int k = 4; k <= SQ; k++) begin
        sa_q[k] <= sa_q[k-1];
        sx_q[k] <= sx_q[k-1];
      end
    end
  end

  // ---------------- stage F+3: select along / across ----------------
  logic signed [RW+33:0] dprod, dprod_r;
  logic signed [DW-1:0]  al_q, ac_q;

  always_comb begin
    dprod   = $signed({1'b0, root_b}) * cd_q[SQ];
    dprod_r = dprod + HALF_TX;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (spec_q_pipe[SQ]) begin
        al_q <= sa_q[SQ];
        ac_q <= sx_q[SQ];
      end else begin
        al_q <= {1'b0, root_a};
        ac_q <= dprod_r[TRIG_BITS+DW-1:TRIG_BITS];
      end
    end
  end

  // ---------------- stages F+4 .. F+5: rotate back, saturate ----------------
  logic signed [2*DW-1:0] r1, r2, r3, r4;
  logic signed [DW+1:0]   r1_q, r2_q, r3_q, r4_q;
  logic signed [DW+2:0]   sx, sy;
  logic signed [DW-1:0]   ox_q, oy_q;

  always_comb begin
    r1 = normal_x_q * al_q + HALF_F;
    r2 = normal_y_q * ac_q + HALF_F;
    r3 = normal_y_q * al_q + HALF_F;
    r4 = normal_x_q * ac_q + HALF_F;
    sx = r1_q - r2_q;
    sy = r3_q + r4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q <= r1[2*DW-1:F];
      r2_q <= r2[2*DW-1:F];
      r3_q <= r3[2*DW-1:F];
      r4_q <= r4[2*DW-1:F];
      ox_q <= (sx < MONE) ? MONE[DW-1:0] : (sx > ONE) ? ONE[DW-1:0] : sx[DW-1:0];
      oy_q <= (sy < MONE) ? MONE[DW-1:0] : (sy > ONE) ? ONE[DW-1:0] : sy[DW-1:0];
    end
  end

  assign out_valid_o   = valid_q[NS];
  assign new_dir_x_o   = ox_q;
  assign new_dir_y_o   = oy_q;
  assign was_diffuse_o = !spec_q_pipe[NS];

endmodule

/* rtl/core/ssd_checker.sv */
// ----------------------------------------------------------------------------
// ssd_checker
// port-level checks of the surface scatter direction block
// ----------------------------------------------------------------------------
module ssd_checker #(
  parameter int DIR_FRAC_BITS = 14
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [DIR_FRAC_BITS+1:0] new_dir_x_o,
  input logic signed [DIR_FRAC_BITS+1:0] new_dir_y_o,
  input logic                           was_diffuse_o
);

  localparam logic signed [DIR_FRAC_BITS+1:0] ONE = (DIR_FRAC_BITS+2)'(1) <<< DIR_FRAC_BITS;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_dir_x_o) &&
    $stable(new_dir_y_o) && $stable(was_diffuse_o))
    else $error("stalled result changed");

  // input backpressure only from a stalled result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  // results saturate to the unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_dir_x_o <= ONE && new_dir_x_o >= -ONE &&
    new_dir_y_o <= ONE && new_dir_y_o >= -ONE)
    else $error("direction out of range");

  // no result during reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind surface_scatter_direction ssd_checker #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_ssd_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the surface scatter direction block: a built-in
// predictor works out each outgoing direction, a checker compares every
// result item in order, and the idling of both channels is varied by phase
// ----------------------------------------------------------------------------
module tb_top
  import ssd_pkg::*;
;

  localparam int DIR_W = 16;
  localparam int SPEC_W = 17;
  localparam int FRAC = 14;
  localparam int RBITS = 16;
  localparam longint ONE = 64'sd16384;
  localparam int LATENCY_PAD = 30;
  localparam int CYCLE_LIMIT = 600000;
  // no register sits at this index, writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic                    diffuse;
  } scatter_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [SPEC_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [DIR_W-1:0] dir_x_i, dir_y_i;
  logic [RBITS-1:0] rand_choice_i, rand_radius_i, rand_angle_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [DIR_W-1:0] new_dir_x_o, new_dir_y_o;
  logic was_diffuse_o;

  surface_scatter_direction u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .dir_x_i, .dir_y_i,
    .rand_choice_i, .rand_radius_i, .rand_angle_i,
    .out_valid_o, .out_stall_i, .new_dir_x_o, .new_dir_y_o, .was_diffuse_o
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the wall configuration
  logic [DIR_W-1:0]  wall_nx;
  logic [DIR_W-1:0]  wall_ny;
  logic [SPEC_W-1:0] wall_spec;

  scatter_t pending_dirs[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  // ---------------------------------------------------------------- predictor

  // product of two fixed point values, rounded half up back to s fraction bits
  function automatic longint mul_rnd(longint a, longint b, int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // sqrt of a Q0.16 fraction, floored to 14 fraction bits
  function automatic longint root_frac(longint unsigned q);
    return longint'(int_sqrt(q << (62 - RBITS)) >> (31 - FRAC));
  endfunction

  // quarter-wave cosine, x in Q0.30 of a quarter turn
  function automatic longint quarter_cos(longint x);
    longint u, acc;
    u = mul_rnd(x, x, TRIG_BITS);
    acc = longint'(COS_COEF[7]);
    for (int k = 6; k >= 1; k--) acc = longint'(COS_COEF[k]) - mul_rnd(acc, u, TRIG_BITS);
    return longint'(COS_COEF[0]) - mul_rnd(acc, u, TRIG_BITS);
  endfunction

  function automatic longint turn_cos(logic [RBITS-1:0] r);
    logic [31:0] phase;
    longint x, full;
    phase = {r, 16'd0};
    x = longint'(phase[29:0]);
    full = 64'sd1 <<< TRIG_BITS;
    case (phase[31:30])
      2'd0: return quarter_cos(x);
      2'd1: return -quarter_cos(full - x);
      2'd2: return -quarter_cos(x);
      default: return quarter_cos(full - x);
    endcase
  endfunction

  function automatic scatter_t scatter_dir(logic signed [DIR_W-1:0] dx_v,
                                           logic signed [DIR_W-1:0] dy_v,
                                           logic [RBITS-1:0] choice,
                                           logic [RBITS-1:0] radius,
                                           logic [RBITS-1:0] angle);
    longint nx, ny, dx, dy, along, across, x, y;
    longint wlo, whi;
    logic specular;
    scatter_t res;
    wlo = -(64'sd1 <<< (DIR_W - 1));
    whi = (64'sd1 <<< (DIR_W - 1)) - 1;
    nx = longint'($signed(wall_nx));
    ny = longint'($signed(wall_ny));
    dx = longint'(dx_v);
    dy = longint'(dy_v);
    specular = (wall_spec >= (1 << RBITS)) || ({1'b0, choice} < wall_spec);
    if (specular) begin
      along = clamp(-(mul_rnd(dx, nx, FRAC) + mul_rnd(dy, ny, FRAC)), wlo, whi);
      across = clamp(mul_rnd(dy, nx, FRAC) - mul_rnd(dx, ny, FRAC), wlo, whi);
    end else begin
      along = root_frac(longint'(radius));
      across = mul_rnd(root_frac((64'd1 << RBITS) - radius), turn_cos(angle), TRIG_BITS);
    end
    x = clamp(mul_rnd(nx, along, FRAC) - mul_rnd(ny, across, FRAC), -ONE, ONE);
    y = clamp(mul_rnd(ny, along, FRAC) + mul_rnd(nx, across, FRAC), -ONE, ONE);
    res.x = x[DIR_W-1:0];
    res.y = y[DIR_W-1:0];
    res.diffuse = ~specular;
    return res;
  endfunction

  // ------------------------------------------------------------------ checker

  // receiver: random stall and in-order comparison of every result item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_dirs.size() == 0) begin
          $error("unexpected result item x=%0d y=%0d", new_dir_x_o, new_dir_y_o);
          mismatches++;
        end else begin
          scatter_t exp_dir;
          exp_dir = pending_dirs.pop_front();
          if (new_dir_x_o !== exp_dir.x) begin
            $error("new_dir_x expected %0d actual %0d", exp_dir.x, new_dir_x_o);
            mismatches++;
          end
          if (new_dir_y_o !== exp_dir.y) begin
            $error("new_dir_y expected %0d actual %0d", exp_dir.y, new_dir_y_o);
            mismatches++;
          end
          if (was_diffuse_o !== exp_dir.diffuse) begin
            $error("was_diffuse expected %0b actual %0b", exp_dir.diffuse, was_diffuse_o);
            mismatches++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------ drivers

  // register write, only called while nothing is in flight
  task automatic cfg_write(logic [1:0] idx, logic [SPEC_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NORMAL_X:    wall_nx = data[DIR_W-1:0];
      REG_NORMAL_Y:    wall_ny = data[DIR_W-1:0];
      REG_SPECULARITY: wall_spec = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // stop sending, let every expected result drain, then wait out LATENCY_PAD, which is longer than the pipeline depth
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  // send one item, hold it until accepted, then maybe idle a while
  task automatic send_hit(logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy,
                          logic [RBITS-1:0] choice, logic [RBITS-1:0] radius,
                          logic [RBITS-1:0] angle);
    int gap;
    in_valid_i <= 1'b1;
    dir_x_i <= dx;
    dir_y_i <= dy;
    rand_choice_i <= choice;
    rand_radius_i <= radius;
    rand_angle_i <= angle;
    do @(posedge clk_i); while (in_stall_o);
    pending_dirs.push_back(scatter_dir(dx, dy, choice, radius, angle));
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [DIR_W-1:0] rand_dir();
    // mostly the legal range, some full-width to reach saturation
    if ($urandom_range(9) == 0) return DIR_W'($urandom);
    return DIR_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic rand_wall();
    case ($urandom_range(3))
      0: cfg_write(REG_SPECULARITY, 17'd0);
      1: cfg_write(REG_SPECULARITY, 17'd65536);
      2: cfg_write(REG_SPECULARITY, SPEC_W'($urandom));
      default: cfg_write(REG_SPECULARITY, SPEC_W'($urandom_range(65536)));
    endcase
    cfg_write(REG_NORMAL_X, {1'b0, rand_dir()});
    cfg_write(REG_NORMAL_Y, {1'b0, rand_dir()});
  endtask

  // -------------------------------------------------------------------- tests

  // reset wall: normal (1,0), always specular; direction extremes
  task automatic test_reset_wall();
    send_hit(16'sd16384, 16'sd0, 16'd0, 16'd0, 16'd0);
    send_hit(-16'sd16384, 16'sd16384, 16'hffff, 16'hffff, 16'hffff);
    send_hit(-16'sd32768, 16'sd32767, 16'd1, 16'd2, 16'd3);
    send_hit(16'sd32767, -16'sd32768, 16'h5555, 16'haaaa, 16'h1234);
    send_hit(16'sd0, 16'sd0, 16'h8000, 16'h8000, 16'h8000);
    drain();
  endtask

  // diffuse path: radius and angle extremes, quadrant borders
  task automatic test_diffuse();
    cfg_write(REG_SPECULARITY, 17'd0);
    cfg_write(REG_NORMAL_X, 17'd0);
    cfg_write(REG_NORMAL_Y, 17'd16384);
    send_hit(16'sd100, 16'sd200, 16'd0, 16'd0, 16'd0);
    send_hit(16'sd100, 16'sd200, 16'hffff, 16'hffff, 16'hffff);
    send_hit(16'sd0, 16'sd0, 16'd7, 16'd32768, 16'd16384);
    send_hit(16'sd0, 16'sd0, 16'd7, 16'd1, 16'd32768);
    send_hit(16'sd0, 16'sd0, 16'd7, 16'd20000, 16'd49152);
    drain();
    // non-unit, negative normal
    cfg_write(REG_NORMAL_X, {1'b0, -16'sd16384});
    cfg_write(REG_NORMAL_Y, {1'b0, -16'sd32768});
    send_hit(16'sd5000, -16'sd9000, 16'd0, 16'd65535, 16'd8192);
    send_hit(-16'sd32768, 16'sd32767, 16'd0, 16'd12345, 16'd60000);
    drain();
  endtask

  // specularity edges: above one, exactly one step, dropped write
  task automatic test_specularity_edges();
    cfg_write(REG_NORMAL_X, 17'd11585);
    cfg_write(REG_NORMAL_Y, 17'd11585);
    cfg_write(REG_SPECULARITY, 17'h1ffff);
    send_hit(16'sd3000, -16'sd4000, 16'hffff, 16'd100, 16'd100);
    drain();
    cfg_write(REG_SPECULARITY, 17'd1);
    send_hit(16'sd3000, -16'sd4000, 16'd0, 16'd100, 16'd100);
    send_hit(16'sd3000, -16'sd4000, 16'd1, 16'd100, 16'd100);
    drain();
    cfg_write(REG_UNUSED, 17'h1ffff);
    send_hit(-16'sd16384, 16'sd16384, 16'd0, 16'd50000, 16'd777);
    send_hit(16'sd16384, 16'sd16384, 16'd2, 16'd50000, 16'd777);
    drain();
  endtask

  // random items over idling phases, wall reconfigured between rounds
  task automatic test_random_phases();
    int idle_set[4] = '{0, 81, 0, 25};
    int stall_set[4] = '{0, 0, 81, 25};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int rnd = 0; rnd < 5; rnd++) begin
        rand_wall();
        for (int n = 0; n < 100; n++) begin
          send_hit(rand_dir(), rand_dir(), RBITS'($urandom), RBITS'($urandom),
                   RBITS'($urandom));
          // hold off once until the pipeline has emptied
          if (ph == 3 && rnd == 2 && n == 50) begin
            in_valid_i <= 1'b0;
            while (pending_dirs.size() != 0) @(posedge clk_i);
          end
        end
        drain();
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_ni = 1'b1;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= REG_NORMAL_X;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    dir_x_i <= '0;
    dir_y_i <= '0;
    rand_choice_i <= '0;
    rand_radius_i <= '0;
    rand_angle_i <= '0;
    wall_nx = 16'd16384;
    wall_ny = 16'd0;
    wall_spec = 17'd65536;
    #1 rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_wall();
    test_diffuse();
    test_specularity_edges();
    test_random_phases();

    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ssd_pkg.sv
rtl/core/ssd_sqrt.sv
rtl/core/surface_scatter_direction.sv
rtl/core/ssd_checker.sv
bench/tb_top.sv
